// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, word types and rounding helpers shared by the quaternion rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;

   // quaternion component products
   localparam int PROD_W  = 2 * DATA_WIDTH;
   // doubled product rounded to FRAC_BITS fraction bits
   localparam int DPROD_W = 2 * DATA_WIDTH - FRAC_BITS + 1;
   // matrix entry: a sum of two rounded products, or one minus such a sum
   localparam int ENTRY_W = ((DPROD_W > FRAC_BITS + 1) ? DPROD_W : FRAC_BITS + 1) + 2;
   localparam int TERM_W  = ENTRY_W + DATA_WIDTH;
   localparam int ACC_W   = TERM_W + 3;
   localparam int SHIFT_W = ACC_W - FRAC_BITS;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [DPROD_W-1:0]    dprod_type;
   typedef logic signed [ENTRY_W-1:0]    entry_type;
   typedef logic signed [TERM_W-1:0]     term_type;
   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic signed [SHIFT_W-1:0]    shift_type;

   localparam logic signed [PROD_W:0] DP_HALF  = (PROD_W + 1)'(1) << (FRAC_BITS - 2);
   localparam entry_type              ENTRY_ONE = ENTRY_W'(1) << FRAC_BITS;
   localparam acc_type                ACC_HALF  = ACC_W'(1) << (FRAC_BITS - 1);
   localparam data_type               DATA_MAX  = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
   localparam data_type               DATA_MIN  = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

   typedef struct packed {
      data_type quat_x;
      data_type quat_y;
      data_type quat_z;
      data_type quat_w;
      data_type vec_x;
      data_type vec_y;
      data_type vec_z;
   } req_word_type;

   typedef struct packed {
      prod_type xx;
      prod_type yy;
      prod_type zz;
      prod_type xy;
      prod_type xz;
      prod_type yz;
      prod_type wx;
      prod_type wy;
      prod_type wz;
      data_type vec_x;
      data_type vec_y;
      data_type vec_z;
   } prod_word_type;

   typedef struct packed {
      entry_type m00;
      entry_type m01;
      entry_type m02;
      entry_type m10;
      entry_type m11;
      entry_type m12;
      entry_type m20;
      entry_type m21;
      entry_type m22;
      data_type  vec_x;
      data_type  vec_y;
      data_type  vec_z;
   } matrix_word_type;

   typedef struct packed {
      term_type t00;
      term_type t01;
      term_type t02;
      term_type t10;
      term_type t11;
      term_type t12;
      term_type t20;
      term_type t21;
      term_type t22;
   } term_word_type;

   typedef struct packed {
      data_type rot_x;
      data_type rot_y;
      data_type rot_z;
      logic     clipped;
   } rsp_word_type;

   typedef struct packed {
      data_type value;
      logic     clip;
   } sat_type;

   // 2*p rounded half up to FRAC_BITS fraction bits
   function automatic dprod_type dprod_round(input prod_type p);
      logic signed [PROD_W:0] s;
      s = {p[PROD_W-1], p} + DP_HALF;
      return s[FRAC_BITS-1 +: DPROD_W];
   endfunction

   function automatic term_type mul_entry(input entry_type m, input data_type v);
      return term_type'(m) * term_type'(v);
   endfunction

   // sum three terms, round half up to an integer, clamp to DATA_WIDTH bits
   function automatic sat_type round_sat(input term_type a, input term_type b,
                                         input term_type c);
      acc_type   acc;
      shift_type sh;
      sat_type   r;
      acc = acc_type'(a) + acc_type'(b) + acc_type'(c) + ACC_HALF;
      sh  = acc[ACC_W-1:FRAC_BITS];
      if ((&sh[SHIFT_W-1:DATA_WIDTH-1]) || !(|sh[SHIFT_W-1:DATA_WIDTH-1])) begin
         r.value = sh[DATA_WIDTH-1:0];
         r.clip  = 1'b0;
      end else begin
         r.value = sh[SHIFT_W-1] ? DATA_MIN : DATA_MAX;
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/qvr_req_if.sv =====
// ----------------------------------------------------------------------------
// qvr_req_if
// Request channel: quaternion and vector word with valid/ready.
// ----------------------------------------------------------------------------
interface qvr_req_if import qvr_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type quat_x;
   data_type quat_y;
   data_type quat_z;
   data_type quat_w;
   data_type vec_x;
   data_type vec_y;
   data_type vec_z;

   modport source (
      output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
      input  ready
   );
   modport sink (
      input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
      output ready
   );
endinterface

// ===== rtl/qvr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qvr_rsp_if
// Response channel: rotated vector word and clip flag with valid/ready.
// ----------------------------------------------------------------------------
interface qvr_rsp_if import qvr_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type rot_x;
   data_type rot_y;
   data_type rot_z;
   logic     clipped;

   modport source (
      output valid, rot_x, rot_y, rot_z, clipped,
      input  ready
   );
   modport sink (
      input  valid, rot_x, rot_y, rot_z, clipped,
      output ready
   );
endinterface

// ===== rtl/qvr_matrix_build.sv =====
// ----------------------------------------------------------------------------
// qvr_matrix_build
// Two stages: quaternion component products, then rounded doubled products
// combined into the nine rotation matrix entries.
// ----------------------------------------------------------------------------
module qvr_matrix_build import qvr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_word_type    in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output matrix_word_type out_word
);

   logic            s1_valid_ff, s1_valid_in;
   logic            s2_valid_ff, s2_valid_in;
   prod_word_type   s1_word_ff, s1_word_in;
   matrix_word_type s2_word_ff, s2_word_in;
   logic            s1_ready, s2_ready;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      s1_word_in.xx    = in_word.quat_x * in_word.quat_x;
      s1_word_in.yy    = in_word.quat_y * in_word.quat_y;
      s1_word_in.zz    = in_word.quat_z * in_word.quat_z;
      s1_word_in.xy    = in_word.quat_x * in_word.quat_y;
      s1_word_in.xz    = in_word.quat_x * in_word.quat_z;
      s1_word_in.yz    = in_word.quat_y * in_word.quat_z;
      s1_word_in.wx    = in_word.quat_w * in_word.quat_x;
      s1_word_in.wy    = in_word.quat_w * in_word.quat_y;
      s1_word_in.wz    = in_word.quat_w * in_word.quat_z;
      s1_word_in.vec_x = in_word.vec_x;
      s1_word_in.vec_y = in_word.vec_y;
      s1_word_in.vec_z = in_word.vec_z;
   end

   always_comb begin
      entry_type xx, yy, zz, xy, xz, yz, wx, wy, wz;
      xx = entry_type'(dprod_round(s1_word_ff.xx));
      yy = entry_type'(dprod_round(s1_word_ff.yy));
      zz = entry_type'(dprod_round(s1_word_ff.zz));
      xy = entry_type'(dprod_round(s1_word_ff.xy));
      xz = entry_type'(dprod_round(s1_word_ff.xz));
      yz = entry_type'(dprod_round(s1_word_ff.yz));
      wx = entry_type'(dprod_round(s1_word_ff.wx));
      wy = entry_type'(dprod_round(s1_word_ff.wy));
      wz = entry_type'(dprod_round(s1_word_ff.wz));
      s2_word_in.m00   = ENTRY_ONE - (yy + zz);
      s2_word_in.m01   = xy - wz;
      s2_word_in.m02   = xz + wy;
      s2_word_in.m10   = xy + wz;
      s2_word_in.m11   = ENTRY_ONE - (xx + zz);
      s2_word_in.m12   = yz - wx;
      s2_word_in.m20   = xz - wy;
      s2_word_in.m21   = yz + wx;
      s2_word_in.m22   = ENTRY_ONE - (xx + yy);
      s2_word_in.vec_x = s1_word_ff.vec_x;
      s2_word_in.vec_y = s1_word_ff.vec_y;
      s2_word_in.vec_z = s1_word_ff.vec_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // advance payload only when the stage takes a new word
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_word_ff <= s1_word_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_word_ff <= s2_word_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

endmodule

// ===== rtl/qvr_rotate_mac.sv =====
// ----------------------------------------------------------------------------
// qvr_rotate_mac
// Two stages: vector times matrix entries, then per-row sum, rounding and
// saturation into the output register.
// ----------------------------------------------------------------------------
module qvr_rotate_mac import qvr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  matrix_word_type in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_word_type    out_word
);

   logic          s3_valid_ff, s3_valid_in;
   logic          s4_valid_ff, s4_valid_in;
   term_word_type s3_word_ff, s3_word_in;
   rsp_word_type  s4_word_ff, s4_word_in;
   logic          s3_ready, s4_ready;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   always_comb begin
      s3_valid_in = s3_ready ? in_valid : s3_valid_ff;
      s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
   end

   always_comb begin
      s3_word_in.t00 = mul_entry(in_word.m00, in_word.vec_x);
      s3_word_in.t01 = mul_entry(in_word.m01, in_word.vec_y);
      s3_word_in.t02 = mul_entry(in_word.m02, in_word.vec_z);
      s3_word_in.t10 = mul_entry(in_word.m10, in_word.vec_x);
      s3_word_in.t11 = mul_entry(in_word.m11, in_word.vec_y);
      s3_word_in.t12 = mul_entry(in_word.m12, in_word.vec_z);
      s3_word_in.t20 = mul_entry(in_word.m20, in_word.vec_x);
      s3_word_in.t21 = mul_entry(in_word.m21, in_word.vec_y);
      s3_word_in.t22 = mul_entry(in_word.m22, in_word.vec_z);
   end

   always_comb begin
      sat_type rx, ry, rz;
      rx = round_sat(s3_word_ff.t00, s3_word_ff.t01, s3_word_ff.t02);
      ry = round_sat(s3_word_ff.t10, s3_word_ff.t11, s3_word_ff.t12);
      rz = round_sat(s3_word_ff.t20, s3_word_ff.t21, s3_word_ff.t22);
      s4_word_in.rot_x   = rx.value;
      s4_word_in.rot_y   = ry.value;
      s4_word_in.rot_z   = rz.value;
      s4_word_in.clipped = rx.clip | ry.clip | rz.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // hold the output word until the sink takes it
   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         s3_word_ff <= s3_word_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_word_ff <= s4_word_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_word  = s4_word_ff;

endmodule

// ===== rtl/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// One register per stage between request accept and response valid
// (component products, matrix entries, entry-vector products, sum).
// Throughput: one word per cycle; a stalled response holds full stages only.
// Reset clears the stage valid bits only; no other state is kept.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate import qvr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qvr_req_if.sink   req_chan,
   qvr_rsp_if.source rsp_chan
);

   req_word_type    req_word;
   rsp_word_type    rsp_word;
   matrix_word_type mtx_word;
   logic            mtx_valid;
   logic            mtx_ready;

   always_comb begin
      req_word.quat_x = req_chan.quat_x;
      req_word.quat_y = req_chan.quat_y;
      req_word.quat_z = req_chan.quat_z;
      req_word.quat_w = req_chan.quat_w;
      req_word.vec_x  = req_chan.vec_x;
      req_word.vec_y  = req_chan.vec_y;
      req_word.vec_z  = req_chan.vec_z;
   end

   qvr_matrix_build u_matrix_build (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (req_word),
      .out_valid (mtx_valid),
      .out_ready (mtx_ready),
      .out_word  (mtx_word)
   );

   qvr_rotate_mac u_rotate_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mtx_valid),
      .in_ready  (mtx_ready),
      .in_word   (mtx_word),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (rsp_word)
   );

   assign rsp_chan.rot_x   = rsp_word.rot_x;
   assign rsp_chan.rot_y   = rsp_word.rot_y;
   assign rsp_chan.rot_z   = rsp_word.rot_z;
   assign rsp_chan.clipped = rsp_word.clipped;

endmodule
